// File: src/multi_pool_bump_allocator_assert.svh
// Assertion macros used by the port checker of the pool allocator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MULTI_POOL_BUMP_ALLOCATOR_ASSERT_SVH
`define MULTI_POOL_BUMP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MPBA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MPBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mpba_pkg.sv
// Shared constants, codes and helpers of the multi-pool bump allocator.
// Used by the RAM-based top level and by its port checker; depends on nothing.
`default_nettype none

package mpba_pkg;

    // Pool layout.
    localparam int POOLS           = 4;
    localparam int MAX_POOL_CHUNKS = 256;
    localparam int MAP_DEPTH       = POOLS * MAX_POOL_CHUNKS;

    // Widths of counts, flat addresses and address sums.
    localparam int CNT_W  = $clog2(MAX_POOL_CHUNKS + 1);
    localparam int ADDR_W = 10;
    localparam int SPAN_W = ADDR_W + 1;
    localparam int POOL_W = (POOLS > 1) ? $clog2(POOLS) : 1;

    // Configuration registers.
    localparam int NUM_CFG    = 4;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int PADDR_W    = CFG_IDX_W + 2;
    localparam int APB_DATA_W = 32;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    // Stream payload layout.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int STATUS_W  = 2;

    // Operation codes carried on s_tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OOM      = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    // A pool's effective size is its register clamped to the pool maximum.
    function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] s;
        if (int'(r) > MAX_POOL_CHUNKS) begin
            s = CNT_W'(MAX_POOL_CHUNKS);
        end else begin
            s = CNT_W'(r);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: src/mpba_ram.sv
// Generic single-port RAM with a registered read port.
// Self-contained; used for the chunk free bitmap of the allocator.
`default_nettype none

module mpba_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire  logic             clk,
    input  wire  logic             we,
    input  wire  logic [AW-1:0]    addr,
    input  wire  logic [WIDTH-1:0] wdata,
    output logic       [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/multi_pool_bump_allocator.sv
// Multi-pool bump allocator. The bitmap RAM port sets the pace: one chunk per cycle in the
// mark walks, a read and a wait per chunk in the tail check. An allocate scans the pools,
// marks the granted chunks and sums the free tails; a free scans, marks, checks the tail
// above the range up to the pointer and sums. The result is loaded once any earlier result
// has left on m_tready, and s_tready rises in the cycle after. Reset is synchronous on
// aresetn: pointers clear, sizes load 256, and s_tready stays low through the bitmap sweep.
`default_nettype none

module multi_pool_bump_allocator (
    input  wire  logic                              aclk,
    input  wire  logic                              aresetn,
    // Request stream.
    input  wire  logic                              s_tvalid,
    output logic                                    s_tready,
    input  wire  logic [mpba_pkg::S_TDATA_W-1:0]    s_tdata,  // chunk_count[8:0], free_address[18:9]
    input  wire  logic                              s_tuser,  // func[0]
    // Result stream.
    output logic                                    m_tvalid,
    input  wire  logic                              m_tready,
    output logic       [mpba_pkg::M_TDATA_W-1:0]    m_tdata,  // alloc_address[9:0], largest_free[18:10]
    output logic       [mpba_pkg::STATUS_W-1:0]     m_tuser,  // status[1:0]
    // Configuration port, APB style.
    input  wire  logic                              psel,
    input  wire  logic                              penable,
    input  wire  logic                              pwrite,
    input  wire  logic [mpba_pkg::PADDR_W-1:0]      paddr,
    input  wire  logic [mpba_pkg::APB_DATA_W-1:0]   pwdata,
    output logic       [mpba_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                    pready
);

    localparam int CNT_W  = mpba_pkg::CNT_W;
    localparam int ADDR_W = mpba_pkg::ADDR_W;
    localparam int SPAN_W = mpba_pkg::SPAN_W;
    localparam int POOL_W = mpba_pkg::POOL_W;
    localparam int CFG_W  = mpba_pkg::CFG_W;
    localparam int PAD_W  = mpba_pkg::M_TDATA_W - ADDR_W - CNT_W;

    // Sequencer states. CLEAR is the bitmap sweep after reset; the SCAN states
    // visit one pool per cycle, the MARK states touch one chunk per cycle, and
    // CHECK/WAIT read the tail above a freed range one bit at a time, CHECK then WAIT.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_MARK,
        ST_FREE_SCAN,
        ST_FREE_MARK,
        ST_FREE_CHECK,
        ST_FREE_WAIT,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t                       state_reg,    state_next;
    logic [ADDR_W-1:0]            clr_cnt_reg,  clr_cnt_next;
    logic [POOL_W-1:0]            pool_reg,     pool_next;
    logic [SPAN_W-1:0]            base_reg,     base_next;
    logic [SPAN_W-1:0]            walk_reg,     walk_next;
    logic [SPAN_W-1:0]            end_reg,      end_next;
    logic [SPAN_W-1:0]            stop_reg,     stop_next;
    logic [CNT_W-1:0]             first_reg,    first_next;
    logic [CNT_W-1:0]             count_reg,    count_next;
    logic [ADDR_W-1:0]            faddr_reg,    faddr_next;
    mpba_pkg::status_t            status_reg,   status_next;
    logic [ADDR_W-1:0]            aaddr_reg,    aaddr_next;
    logic [CNT_W-1:0]             largest_reg,  largest_next;
    logic [CNT_W-1:0]             nf_reg  [mpba_pkg::POOLS];
    logic [CNT_W-1:0]             nf_next [mpba_pkg::POOLS];
    logic [CFG_W-1:0]             cfg_reg  [mpba_pkg::NUM_CFG];
    logic [CFG_W-1:0]             cfg_next [mpba_pkg::NUM_CFG];
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [mpba_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [mpba_pkg::STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    // Bitmap RAM port.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    // Shared pool unit: size, pointer and free tail of the pool under the scan
    // index, plus the address sums that the free scan compares against.
    logic [CNT_W-1:0]  cur_size;
    logic [CNT_W-1:0]  cur_nf;
    logic [CNT_W-1:0]  cur_tail;
    logic [CNT_W-1:0]  cur_nf_clip;
    logic [SPAN_W-1:0] pool_end;
    logic [SPAN_W-1:0] faddr_ext;
    logic [SPAN_W-1:0] range_end;
    logic              in_pool;
    logic              last_pool;
    logic              apb_write;
    logic              in_xfer;

    assign apb_write = psel & penable & pwrite & pready;
    assign in_xfer   = s_tvalid & s_tready;
    assign last_pool = (pool_reg == POOL_W'(mpba_pkg::POOLS - 1));

    always_comb begin
        if (int'(pool_reg) < mpba_pkg::NUM_CFG) begin
            cur_size = mpba_pkg::clamp_size(cfg_reg[mpba_pkg::CFG_IDX_W'(pool_reg)]);
        end else begin
            cur_size = '0;
        end
        cur_nf = nf_reg[pool_reg];
        // A pointer past a shrunk pool leaves no free tail.
        if (cur_nf >= cur_size) begin
            cur_tail    = '0;
            cur_nf_clip = cur_size;
        end else begin
            cur_tail    = cur_size - cur_nf;
            cur_nf_clip = cur_nf;
        end
        pool_end  = base_reg + SPAN_W'(cur_size);
        faddr_ext = SPAN_W'(faddr_reg);
        range_end = faddr_ext + SPAN_W'(count_reg);
        in_pool   = (faddr_ext >= base_reg) && (range_end <= pool_end);
    end

    // The bitmap is written during the clearing sweep and the mark walks, and
    // read one chunk at a time while checking the tail above a freed range.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = walk_reg[ADDR_W-1:0];
        ram_wdata = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 1'b1;
            end
            ST_ALLOC_MARK: begin
                ram_we    = (walk_reg != end_reg);
                ram_wdata = 1'b0;
            end
            ST_FREE_MARK: begin
                ram_we    = (walk_reg != end_reg);
                ram_wdata = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mpba_ram #(
        .WIDTH (1),
        .DEPTH (mpba_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pool_next     = pool_reg;
        base_next     = base_reg;
        walk_next     = walk_reg;
        end_next      = end_reg;
        stop_next     = stop_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        faddr_next    = faddr_reg;
        status_next   = status_reg;
        aaddr_next    = aaddr_reg;
        largest_next  = largest_reg;
        nf_next       = nf_reg;
        cfg_next      = cfg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // Register writes are taken in every state, including the sweep.
        if (apb_write) begin
            cfg_next[paddr[mpba_pkg::PADDR_W-1:2]] = pwdata[CFG_W-1:0];
        end

        // A result that is taken frees the output register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(mpba_pkg::MAP_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (in_xfer) begin
                    count_next  = s_tdata[CNT_W-1:0];
                    faddr_next  = s_tdata[CNT_W +: ADDR_W];
                    pool_next   = '0;
                    base_next   = '0;
                    status_next = mpba_pkg::STATUS_OK;
                    aaddr_next  = '0;
                    if (s_tuser == mpba_pkg::FUNC_FREE) begin
                        state_next = ST_FREE_SCAN;
                    end else begin
                        state_next = ST_ALLOC_SCAN;
                    end
                end
            end

            ST_ALLOC_SCAN: begin
                if (cur_tail >= count_reg) begin
                    // First pool with room wins; the pointer bumps right away.
                    walk_next         = base_reg + SPAN_W'(cur_nf);
                    end_next          = base_reg + SPAN_W'(cur_nf) + SPAN_W'(count_reg);
                    aaddr_next        = ADDR_W'(base_reg + SPAN_W'(cur_nf));
                    nf_next[pool_reg] = cur_nf + count_reg;
                    state_next        = ST_ALLOC_MARK;
                end else begin
                    base_next = pool_end;
                    if (last_pool) begin
                        status_next  = mpba_pkg::STATUS_OOM;
                        pool_next    = '0;
                        largest_next = '0;
                        state_next   = ST_SUM;
                    end else begin
                        pool_next = pool_reg + 1'b1;
                    end
                end
            end

            ST_ALLOC_MARK: begin
                if (walk_reg == end_reg) begin
                    pool_next    = '0;
                    largest_next = '0;
                    state_next   = ST_SUM;
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
            end

            ST_FREE_SCAN: begin
                if (in_pool) begin
                    first_next = CNT_W'(faddr_ext - base_reg);
                    walk_next  = faddr_ext;
                    end_next   = range_end;
                    // The tail check never runs past the pool's end.
                    stop_next  = base_reg + SPAN_W'(cur_nf_clip);
                    state_next = ST_FREE_MARK;
                end else begin
                    base_next = pool_end;
                    if (last_pool) begin
                        status_next  = mpba_pkg::STATUS_BAD_ADDR;
                        pool_next    = '0;
                        largest_next = '0;
                        state_next   = ST_SUM;
                    end else begin
                        pool_next = pool_reg + 1'b1;
                    end
                end
            end

            ST_FREE_MARK: begin
                if (walk_reg == end_reg) begin
                    state_next = ST_FREE_CHECK;
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
            end

            ST_FREE_CHECK: begin
                if (walk_reg >= stop_reg) begin
                    // Everything up to the pointer is free: pull it back to the
                    // range start, which may also raise it.
                    nf_next[pool_reg] = first_reg;
                    pool_next         = '0;
                    largest_next      = '0;
                    state_next        = ST_SUM;
                end else begin
                    state_next = ST_FREE_WAIT;
                end
            end

            ST_FREE_WAIT: begin
                if (!ram_rdata) begin
                    pool_next    = '0;
                    largest_next = '0;
                    state_next   = ST_SUM;
                end else begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_FREE_CHECK;
                end
            end

            ST_SUM: begin
                if (cur_tail > largest_reg) begin
                    largest_next = cur_tail;
                end
                if (last_pool) begin
                    state_next = ST_OUT;
                end else begin
                    pool_next = pool_reg + 1'b1;
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {PAD_W'(0), largest_reg, aaddr_reg};
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < mpba_pkg::POOLS; i++) begin
                nf_reg[i] <= '0;
            end
            for (int i = 0; i < mpba_pkg::NUM_CFG; i++) begin
                cfg_reg[i] <= mpba_pkg::CFG_RESET;
            end
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            nf_reg       <= nf_next;
            cfg_reg      <= cfg_next;
            pool_reg     <= pool_next;
            base_reg     <= base_next;
            walk_reg     <= walk_next;
            end_reg      <= end_next;
            stop_reg     <= stop_next;
            first_reg    <= first_next;
            count_reg    <= count_next;
            faddr_reg    <= faddr_next;
            status_reg   <= status_next;
            aaddr_reg    <= aaddr_next;
            largest_reg  <= largest_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    // The operation is decoded at accept time, so only the idle state takes a transfer.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = {(mpba_pkg::APB_DATA_W - CFG_W)'(0), cfg_reg[paddr[mpba_pkg::PADDR_W-1:2]]};

endmodule

`default_nettype wire

// File: src/mpba_checker.sv
// Port-level checker for the multi-pool bump allocator, bound to the top level.
// Depends on mpba_pkg and the assertion macros in multi_pool_bump_allocator_assert.svh.
`default_nettype none

`include "multi_pool_bump_allocator_assert.svh"

module mpba_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [mpba_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [mpba_pkg::STATUS_W-1:0]     m_tuser
);

    // A stalled result keeps its payload until the transfer completes.
    `MPBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // The block works on one request at a time.
    `MPBA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // A failed request never reports a granted address.
    `MPBA_ASSERT_NOW(a_fail_addr_zero, aclk, aresetn, m_tvalid && (m_tuser != mpba_pkg::STATUS_OK), m_tdata[mpba_pkg::ADDR_W-1:0] == '0, "address on failed request")

    // The largest free tail never exceeds the pool maximum.
    `MPBA_ASSERT_NOW(a_largest_bound, aclk, aresetn, m_tvalid, int'(m_tdata[mpba_pkg::ADDR_W +: mpba_pkg::CNT_W]) <= mpba_pkg::MAX_POOL_CHUNKS, "largest free tail out of range")

endmodule

bind multi_pool_bump_allocator mpba_checker u_mpba_checker (.*);

`default_nettype wire

// File: dv/multi_pool_bump_allocator_test.sv
// Self-checking testbench for the multi-pool bump allocator: directed table, then random phases.
// Depends on mpba_pkg and multi_pool_bump_allocator; predicts every result in-bench.
module multi_pool_bump_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W          = mpba_pkg::ADDR_W;
    localparam int CNT_W           = mpba_pkg::CNT_W;
    localparam int CFG_W           = mpba_pkg::CFG_W;
    localparam int NUM_CFG         = mpba_pkg::NUM_CFG;
    localparam int POOLS           = mpba_pkg::POOLS;
    localparam int MAP_DEPTH       = mpba_pkg::MAP_DEPTH;
    localparam int MAX_POOL_CHUNKS = mpba_pkg::MAX_POOL_CHUNKS;
    localparam int S_TDATA_W       = mpba_pkg::S_TDATA_W;
    localparam int M_TDATA_W       = mpba_pkg::M_TDATA_W;
    localparam int STATUS_W        = mpba_pkg::STATUS_W;
    localparam int PADDR_W         = mpba_pkg::PADDR_W;
    localparam int APB_DATA_W      = mpba_pkg::APB_DATA_W;

    // Register map: pool p's size register sits at byte address 4 * (REG_POOL0_CHUNKS + p).
    localparam int REG_POOL0_CHUNKS = 0;

    // The limit leaves a wide margin over the slowest request (a free that walks a whole pool)
    // and over the bitmap clearing pass after reset.
    localparam int STALL_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 1000;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int FIXED_PHASES    = 6;
    localparam int RANDOM_PHASES   = 2;
    // Receiver and sender never idle during this phase.
    localparam int STEADY_PHASE    = 3;

    typedef struct packed {
        mpba_pkg::status_t   status;
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    largest;
    } alloc_reply_t;

    typedef struct packed {
        logic                func;
        logic [CNT_W-1:0]    count;
        logic [ADDR_W-1:0]   faddr;
        bit                  typed;
        alloc_reply_t        reply;
    } request_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    count;
    } grant_t;

    localparam alloc_reply_t UNCHECKED = '{mpba_pkg::STATUS_OK, 10'd0, 9'd0};

    // Directed requests, starting from the reset layout of four 256-chunk pools. The typed
    // replies follow directly from that layout; the last rows are left to the predictor.
    localparam int DIRECTED_ROWS = 23;
    localparam request_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{mpba_pkg::FUNC_ALLOC, 9'd0, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd256, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd511, 10'd1023, 1'b1, '{mpba_pkg::STATUS_OOM, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd257, 10'd0, 1'b1, '{mpba_pkg::STATUS_OOM, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd1, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd256, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd0, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd256, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd1, 10'd256, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd1, 10'd1023, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd2, 10'd1023, 1'b1,
          '{mpba_pkg::STATUS_BAD_ADDR, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd511, 10'd0, 1'b1,
          '{mpba_pkg::STATUS_BAD_ADDR, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd10, 10'd250, 1'b1,
          '{mpba_pkg::STATUS_BAD_ADDR, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd0, 10'd768, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd256, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd4, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd4, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd4, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd4, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd4, 10'd4, 1'b1, '{mpba_pkg::STATUS_OK, 10'd0, 9'd256}},
        '{mpba_pkg::FUNC_ALLOC, 9'd4, 10'd0, 1'b1, '{mpba_pkg::STATUS_OK, 10'd4, 9'd256}},
        '{mpba_pkg::FUNC_FREE, 9'd511, 10'd1023, 1'b0, UNCHECKED},
        '{mpba_pkg::FUNC_ALLOC, 9'd255, 10'd0, 1'b0, UNCHECKED},
        '{mpba_pkg::FUNC_FREE, 9'd0, 10'd0, 1'b0, UNCHECKED},
        '{mpba_pkg::FUNC_ALLOC, 9'd341, 10'd682, 1'b0, UNCHECKED},
        '{mpba_pkg::FUNC_FREE, 9'd341, 10'd682, 1'b0, UNCHECKED}
    };

    // Pool sizes of the fixed phases: the reset layout, zero-size pools, over-range values that
    // clamp, small pools that fill up quickly, and mixes with zero-size and over-range pools.
    localparam int PHASE_SIZES [FIXED_PHASES][NUM_CFG] = '{
        '{256, 256, 256, 256},
        '{0,   0,   0,   0},
        '{511, 511, 511, 511},
        '{16,  32,  8,   64},
        '{1,   0,   256, 3},
        '{300, 5,   0,   100}
    };

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic                    s_tuser  = mpba_pkg::FUNC_ALLOC;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [PADDR_W-1:0]      paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    multi_pool_bump_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the allocator: size registers, bump pointers and the free bitmap.
    logic [CFG_W-1:0]  pool_size_reg [NUM_CFG];
    logic [CNT_W-1:0]  pool_ptr      [POOLS];
    bit                chunk_free    [MAP_DEPTH];

    alloc_reply_t      replies_due [$];
    int                mismatches = 0;
    bit                steady     = 1'b0;

    function automatic void report_mismatch(input string what);
        if (mismatches < 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatches++;
    endfunction

    // A pool's usable size is its register clamped to the pool maximum.
    function automatic int pool_chunks(input int p);
        int r;
        r = int'(pool_size_reg[p]);
        return (r > MAX_POOL_CHUNKS) ? MAX_POOL_CHUNKS : r;
    endfunction

    // A pointer left beyond a shrunk pool leaves a free tail of zero.
    function automatic int pool_tail(input int p);
        int s;
        s = pool_chunks(p);
        return (int'(pool_ptr[p]) >= s) ? 0 : s - int'(pool_ptr[p]);
    endfunction

    // Applies one request to the shadow state and returns the reply the block must give.
    function automatic alloc_reply_t serve_request(input logic func,
                                                   input logic [CNT_W-1:0] count,
                                                   input logic [ADDR_W-1:0] faddr);
        alloc_reply_t r;
        int base, first, last, stop, s, j, largest;
        bit found, clear;
        r = '{mpba_pkg::STATUS_OK, '0, '0};
        base = 0;
        found = 1'b0;
        largest = 0;
        for (int p = 0; p < POOLS; p++) begin
            s = pool_chunks(p);
            if (found) begin
                // Request already served by an earlier pool.
            end else if (func == mpba_pkg::FUNC_ALLOC) begin
                if (pool_tail(p) >= int'(count)) begin
                    first = int'(pool_ptr[p]);
                    for (j = 0; j < int'(count); j++) begin
                        chunk_free[base + first + j] = 1'b0;
                    end
                    pool_ptr[p] = CNT_W'(first + int'(count));
                    r.addr = ADDR_W'(base + first);
                    found = 1'b1;
                end
            end else if (int'(faddr) >= base && int'(faddr) + int'(count) <= base + s) begin
                first = int'(faddr) - base;
                last = first + int'(count);
                // The walk toward the pointer never goes past the pool's end.
                stop = (int'(pool_ptr[p]) < s) ? int'(pool_ptr[p]) : s;
                clear = 1'b1;
                for (j = first; j < last; j++) begin
                    chunk_free[base + j] = 1'b1;
                end
                for (j = last; j < stop && clear; j++) begin
                    if (!chunk_free[base + j]) begin
                        clear = 1'b0;
                    end
                end
                // The pointer drops to the range start, or rises to it when it lay below.
                if (clear) begin
                    pool_ptr[p] = CNT_W'(first);
                end
                found = 1'b1;
            end
            base += s;
        end
        if (!found) begin
            r.status = (func == mpba_pkg::FUNC_ALLOC) ? mpba_pkg::STATUS_OOM
                                                      : mpba_pkg::STATUS_BAD_ADDR;
        end
        for (int p = 0; p < POOLS; p++) begin
            if (pool_tail(p) > largest) begin
                largest = pool_tail(p);
            end
        end
        r.largest = CNT_W'(largest);
        return r;
    endfunction

    // The receiver stalls at random, with a chance of 27 in 100, except in the steady phase.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 27);
    end

    // Every result transfer is compared field by field with the oldest outstanding reply.
    always @(posedge aclk) begin : check_replies
        alloc_reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{mpba_pkg::status_t'(m_tuser), m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: CNT_W]};
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d addr %0d largest %0d",
                                          got.status, got.addr, got.largest));
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.addr !== want.addr ||
                        got.largest !== want.largest) begin
                    report_mismatch($sformatf(
                        "status %0d/%0d addr %0d/%0d largest %0d/%0d (expected/actual)",
                        want.status, got.status, want.addr, got.addr,
                        want.largest, got.largest));
                end
            end
        end
    end

    // Ends the run when neither stream has made a transfer for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

    // APB write: setup cycle, then the access cycle that commits at the rising edge.
    task automatic write_pool_size(input int pool, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'((REG_POOL0_CHUNKS + pool) * 4);
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pool_size_reg[pool] = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB read of one size register, compared with the shadow copy.
    task automatic check_pool_size(input int pool);
        logic [APB_DATA_W-1:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'((REG_POOL0_CHUNKS + pool) * 4);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (got !== APB_DATA_W'(pool_size_reg[pool])) begin
            report_mismatch($sformatf("pool %0d size register %0d/%0d (expected/actual)",
                                      pool, pool_size_reg[pool], got));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Presents one request after a random gap and waits for its transfer. Called just after
    // a falling edge with nothing assigned yet in that step; returns just after the next one.
    task automatic send_request(input logic func, input logic [CNT_W-1:0] count,
                                input logic [ADDR_W-1:0] faddr, input bit typed,
                                input alloc_reply_t typed_reply, output alloc_reply_t reply);
        // Now and then the sender holds off until every outstanding reply is back.
        if (!steady && $urandom_range(49) == 0) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while (replies_due.size() != 0);
        end
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= S_TDATA_W'({faddr, count});
        do @(posedge aclk); while (!s_tready);
        reply = serve_request(func, count, faddr);
        replies_due.push_back(typed ? typed_reply : reply);
        @(negedge aclk);
    endtask

    // Lowers valid and waits until every reply has come back, leaving the block idle.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (replies_due.size() != 0);
    endtask

    initial begin : stimulus
        alloc_reply_t reply;
        grant_t grants [$];
        logic func;
        logic [CNT_W-1:0] count;
        logic [ADDR_W-1:0] faddr;
        int pick, idx, sel, size;

        for (int p = 0; p < NUM_CFG; p++) begin
            pool_size_reg[p] = mpba_pkg::CFG_RESET;
        end
        for (int p = 0; p < POOLS; p++) begin
            pool_ptr[p] = '0;
        end
        for (int a = 0; a < MAP_DEPTH; a++) begin
            chunk_free[a] = 1'b1;
        end

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        // The bitmap clearing pass keeps s_tready low; wait until the block takes requests.
        do @(negedge aclk); while (!s_tready);
        for (int p = 0; p < NUM_CFG; p++) begin
            check_pool_size(p);
        end

        @(negedge aclk);
        foreach (DIRECTED[i]) begin
            send_request(DIRECTED[i].func, DIRECTED[i].count, DIRECTED[i].faddr,
                         DIRECTED[i].typed, DIRECTED[i].reply, reply);
        end

        for (int ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
            // Sizes change only while the block is idle; the layout shifts under the bitmap.
            drain_replies();
            for (int p = 0; p < NUM_CFG; p++) begin
                if (ph < FIXED_PHASES) begin
                    size = PHASE_SIZES[ph][p];
                end else if ($urandom_range(3) == 0) begin
                    size = $urandom_range(511);
                end else begin
                    size = $urandom_range(1, 48);
                end
                write_pool_size(p, CFG_W'(size));
                check_pool_size(p);
            end
            grants.delete();
            steady = (ph == STEADY_PHASE);
            @(negedge aclk);

            // Mostly allocations and frees of granted ranges, so that pointers climb and
            // roll back; the rest are frees of arbitrary ranges.
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    func = mpba_pkg::FUNC_ALLOC;
                    faddr = ADDR_W'($urandom);
                    sel = $urandom_range(99);
                    if (sel < 5) begin
                        count = '0;
                    end else if (sel < 75) begin
                        count = CNT_W'($urandom_range(1, 8));
                    end else if (sel < 92) begin
                        count = CNT_W'($urandom_range(9, 64));
                    end else if (sel < 98) begin
                        count = CNT_W'($urandom_range(65, 256));
                    end else begin
                        count = CNT_W'($urandom_range(257, 511));
                    end
                end else if (pick < 82 && grants.size() != 0) begin
                    // Freeing the newest grant lets the pointer fall back.
                    if ($urandom_range(9) < 6) begin
                        idx = grants.size() - 1;
                    end else begin
                        idx = $urandom_range(grants.size() - 1);
                    end
                    func = mpba_pkg::FUNC_FREE;
                    faddr = grants[idx].addr;
                    count = grants[idx].count;
                    grants.delete(idx);
                end else begin
                    func = mpba_pkg::FUNC_FREE;
                    faddr = ADDR_W'($urandom_range(1023));
                    if ($urandom_range(3) == 0) begin
                        count = CNT_W'($urandom_range(511));
                    end else begin
                        count = CNT_W'($urandom_range(16));
                    end
                end
                send_request(func, count, faddr, 1'b0, UNCHECKED, reply);
                if (func == mpba_pkg::FUNC_ALLOC && reply.status == mpba_pkg::STATUS_OK &&
                        count != 0) begin
                    grants.push_back('{reply.addr, count});
                end
            end
            steady = 1'b0;
        end

        drain_replies();
        // Any late, unrequested result would show up during this settling time.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
